// ----- rtl/rtfmae_pkg.sv -----
`timescale 1ns / 1ps

package rtfmae_pkg;

  // Table geometry and storage width
  localparam int ROWS       = 10;
  localparam int COLS       = 10;
  localparam int WORD_BITS  = 32;
  localparam int CELL_COUNT = ROWS * COLS;

  // Fixed port field widths
  localparam int MODE_W    = 2;
  localparam int POS_W     = 7;
  localparam int IN_WORD_W = 32;
  localparam int FOUND_W   = 8;
  localparam int OUT_W     = 32;
  localparam int STATUS_W  = 3;

  // Derived internal widths
  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W  = $clog2(ROWS + 1);
  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LEN_W  = $clog2(COLS + 1);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EDIT   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef logic [WORD_BITS-1:0] cell_t;

  typedef struct packed {
    logic [MODE_W-1:0]           mode;
    logic [POS_W-1:0]            position;
    logic signed [IN_WORD_W-1:0] word;
    logic                        erase_flag;
  } item_t;

  typedef struct packed {
    logic signed [FOUND_W-1:0]  found_position;
    logic signed [OUT_W-1:0]    old_word;
    logic signed [OUT_W-1:0]    new_word;
    logic [STATUS_W-1:0]        status;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cell_t             wr_data;
  } mem_req_t;

  // Sign-extend the port word, then keep the stored width
  function automatic cell_t to_cell(input logic signed [IN_WORD_W-1:0] w);
    logic signed [63:0] ext;
    ext = 64'(w);
    return ext[WORD_BITS-1:0];
  endfunction

  // Stored word to port width (zero-extended, then truncated)
  function automatic logic [OUT_W-1:0] to_out(input cell_t c);
    logic [63:0] z;
    z = 64'(c);
    return z[OUT_W-1:0];
  endfunction

endpackage

// ----- rtl/rtfmae_if.sv -----
`timescale 1ns / 1ps

interface rtfmae_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [rtfmae_pkg::MODE_W-1:0]            mode;
  logic [rtfmae_pkg::POS_W-1:0]             position;
  logic signed [rtfmae_pkg::IN_WORD_W-1:0]  word;
  logic                                     erase_flag;

  modport source (output valid, mode, position, word, erase_flag, input ready);
  modport sink   (input valid, mode, position, word, erase_flag, output ready);
endinterface

interface rtfmae_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rtfmae_pkg::FOUND_W-1:0]  found_position;
  logic signed [rtfmae_pkg::OUT_W-1:0]    old_word;
  logic signed [rtfmae_pkg::OUT_W-1:0]    new_word;
  logic [rtfmae_pkg::STATUS_W-1:0]        status;

  modport source (output valid, found_position, old_word, new_word, status, input ready);
  modport sink   (input valid, found_position, old_word, new_word, status, output ready);
endinterface

// ----- rtl/rtfmae_cell_mem.sv -----
`timescale 1ns / 1ps

module rtfmae_cell_mem (
  input  logic                 clk,
  input  rtfmae_pkg::mem_req_t mreq,
  output rtfmae_pkg::cell_t    rd_data
);

  rtfmae_pkg::cell_t mem [rtfmae_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_data <= mem[mreq.rd_addr];
    end
  end

endmodule

// ----- rtl/rtfmae_seq.sv -----
`timescale 1ns / 1ps

module rtfmae_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtfmae_pkg::item_t    item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rtfmae_pkg::res_t     res,
  output rtfmae_pkg::mem_req_t mreq,
  input  rtfmae_pkg::cell_t    rd_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_MODW = 4'd3;
  localparam logic [3:0] S_SHR  = 4'd4;
  localparam logic [3:0] S_SHW  = 4'd5;
  localparam logic [3:0] S_APP  = 4'd6;
  localparam logic [3:0] S_APW  = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]                        state;
  rtfmae_pkg::item_t                 op;
  rtfmae_pkg::cell_t                 word_c;
  logic [rtfmae_pkg::CNT_W-1:0]      row;
  logic [rtfmae_pkg::LEN_W-1:0]      col;
  logic [rtfmae_pkg::POS_W-1:0]      rem;
  logic                              pend;
  logic [rtfmae_pkg::ADDR_W-1:0]     pend_addr;
  logic [rtfmae_pkg::CNT_W-1:0]      rows_in_use;
  logic [rtfmae_pkg::LEN_W-1:0]      row_len [rtfmae_pkg::ROWS];

  logic [rtfmae_pkg::RIDX_W-1:0]     row_idx;
  logic [rtfmae_pkg::LEN_W-1:0]      cur_len;
  logic [rtfmae_pkg::LEN_W-1:0]      col_p1;
  logic [rtfmae_pkg::ADDR_W-1:0]     cur_addr;
  logic                              in_range;
  logic                              col_ok;
  logic                              hit;
  logic                              need_row;
  logic                              is_mod;

  // single length read port, shared by every operation
  assign row_idx  = row[rtfmae_pkg::RIDX_W-1:0];
  assign cur_len  = row_len[row_idx];
  assign col_p1   = col + rtfmae_pkg::LEN_W'(1);
  assign cur_addr = rtfmae_pkg::ADDR_W'(row * rtfmae_pkg::COLS + col);
  assign in_range = row < rows_in_use;
  assign col_ok   = col < cur_len;
  assign hit      = pend && (rd_data == word_c);
  assign need_row = (rows_in_use == '0) ||
                    (cur_len >= rtfmae_pkg::LEN_W'(rtfmae_pkg::COLS));
  assign is_mod   = op.mode == rtfmae_pkg::MODE_MODIFY;

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_FIN;

  always_comb begin
    mreq.rd_en   = 1'b0;
    mreq.rd_addr = cur_addr;
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = cur_addr;
    mreq.wr_data = word_c;
    case (state)
      S_SCAN: begin
        mreq.rd_en = !hit && in_range && col_ok;
      end
      S_CHK: begin
        mreq.rd_en   = 1'b1;
        mreq.wr_data = '0;
        mreq.wr_en   = in_range && col_ok &&
                       (op.mode == rtfmae_pkg::MODE_EDIT) && !op.erase_flag;
      end
      S_MODW: begin
        mreq.wr_en = 1'b1;
      end
      S_SHR: begin
        mreq.rd_addr = cur_addr + rtfmae_pkg::ADDR_W'(1);
        mreq.rd_en   = col_p1 < cur_len;
      end
      S_SHW: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = rd_data;
      end
      S_APW: begin
        mreq.wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend        <= 1'b0;
      rows_in_use <= '0;
      for (int i = 0; i < rtfmae_pkg::ROWS; i++) begin
        row_len[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op                 <= item;
            word_c             <= rtfmae_pkg::to_cell(item.word);
            res.found_position <= '1;
            col                <= '0;
            rem                <= item.position;
            pend               <= 1'b0;
            case (item.mode)
              rtfmae_pkg::MODE_FIND: begin
                res.old_word <= '0;
                res.new_word <= '0;
                res.status   <= rtfmae_pkg::ST_OK;
                row          <= '0;
                state        <= S_SCAN;
              end
              rtfmae_pkg::MODE_APPEND: begin
                res.old_word <= '0;
                res.new_word <= '0;
                res.status   <= rtfmae_pkg::ST_OK;
                row          <= rows_in_use - rtfmae_pkg::CNT_W'(1);
                state        <= S_APP;
              end
              default: begin
                row <= '0;
                if (int'(item.position) >= rtfmae_pkg::CELL_COUNT) begin
                  // modify reports -1 words on a bad index
                  res.status   <= rtfmae_pkg::ST_INVALID;
                  res.old_word <= {rtfmae_pkg::OUT_W{item.mode == rtfmae_pkg::MODE_MODIFY}};
                  res.new_word <= {rtfmae_pkg::OUT_W{item.mode == rtfmae_pkg::MODE_MODIFY}};
                  state        <= S_FIN;
                end else begin
                  res.status   <= rtfmae_pkg::ST_OK;
                  res.old_word <= '0;
                  res.new_word <= '0;
                  state        <= S_DIV;
                end
              end
            endcase
          end
        end
        // row/column split by repeated subtraction of the row width
        S_DIV: begin
          if (rem >= rtfmae_pkg::POS_W'(rtfmae_pkg::COLS)) begin
            rem <= rem - rtfmae_pkg::POS_W'(rtfmae_pkg::COLS);
            row <= row + rtfmae_pkg::CNT_W'(1);
          end else begin
            col   <= rtfmae_pkg::LEN_W'(rem);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!(in_range && col_ok)) begin
            res.status <= rtfmae_pkg::ST_MISSING;
            if (is_mod) begin
              res.old_word <= '1;
              res.new_word <= '1;
            end
            state <= S_FIN;
          end else if (is_mod) begin
            state <= S_MODW;
          end else if (op.erase_flag) begin
            state <= S_SHR;
          end else begin
            state <= S_FIN;
          end
        end
        S_MODW: begin
          res.old_word <= rtfmae_pkg::to_out(rd_data);
          res.new_word <= rtfmae_pkg::to_out(word_c);
          state        <= S_FIN;
        end
        S_SHR: begin
          if (col_p1 < cur_len) begin
            state <= S_SHW;
          end else begin
            row_len[row_idx] <= cur_len - rtfmae_pkg::LEN_W'(1);
            state            <= S_FIN;
          end
        end
        S_SHW: begin
          col   <= col_p1;
          state <= S_SHR;
        end
        S_APP: begin
          if (need_row) begin
            if (rows_in_use >= rtfmae_pkg::CNT_W'(rtfmae_pkg::ROWS)) begin
              res.status <= rtfmae_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              rows_in_use <= rows_in_use + rtfmae_pkg::CNT_W'(1);
              row         <= rows_in_use;
              col         <= '0;
              state       <= S_APW;
            end
          end else begin
            col   <= cur_len;
            state <= S_APW;
          end
        end
        S_APW: begin
          row_len[row_idx] <= col_p1;
          state            <= S_FIN;
        end
        // one read issued per cycle except on a row change; the compare uses the registered read data
        S_SCAN: begin
          if (hit) begin
            res.found_position <= rtfmae_pkg::FOUND_W'(pend_addr);
            state              <= S_FIN;
          end else if (!in_range) begin
            res.status <= rtfmae_pkg::ST_NOTFOUND;
            state      <= S_FIN;
          end else if (col_ok) begin
            pend      <= 1'b1;
            pend_addr <= cur_addr;
            col       <= col_p1;
          end else begin
            pend <= 1'b0;
            row  <= row + rtfmae_pkg::CNT_W'(1);
            col  <= '0;
          end
        end
        S_FIN: begin
          pend <= 1'b0;
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ragged_table_find_modify_append_erase_top.sv -----
// Append checks the last row and writes one cell; modify and replace first split the
// position by repeated subtraction; remove also shifts each later word of the row down;
// find reads entries row by row until a match. Results leave through an output register.
// Throughput: one operation at a time; the shared cell memory and the sequencer set it.
// Reset (rst, synchronous, active high) empties the table; cell contents are not cleared.
`timescale 1ns / 1ps

module ragged_table_find_modify_append_erase_top (
  input  logic         clk,
  input  logic         rst,
  rtfmae_req_if.sink   req,
  rtfmae_rsp_if.source rsp
);

  rtfmae_pkg::item_t    item;
  rtfmae_pkg::res_t     res;
  rtfmae_pkg::mem_req_t mreq;
  rtfmae_pkg::cell_t    rd_data;
  logic                 seq_ready;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid;
  rtfmae_pkg::res_t     out_res;

  // Request payload packed for the sequencer
  assign item.mode       = req.mode;
  assign item.position   = req.position;
  assign item.word       = req.word;
  assign item.erase_flag = req.erase_flag;

  // Hold off new requests while in reset
  assign req.ready = seq_ready && !rst;

  // Sequencer: position split, row-length bookkeeping, scan and shift control
  rtfmae_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid && !rst),
    .in_ready  (seq_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mreq      (mreq),
    .rd_data   (rd_data)
  );

  // Cell storage: one write and one registered read per cycle
  rtfmae_cell_mem u_mem (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  // Output register: a finished result moves here so the sequencer can
  // return to idle while the consumer stalls.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found_position = out_res.found_position;
  assign rsp.old_word       = out_res.old_word;
  assign rsp.new_word       = out_res.new_word;
  assign rsp.status         = out_res.status;

endmodule

// ----- rtl/rtfmae_checker.sv -----
`timescale 1ns / 1ps

module rtfmae_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   req_valid,
  input logic                                   req_ready,
  input logic                                   rsp_valid,
  input logic                                   rsp_ready,
  input logic signed [rtfmae_pkg::FOUND_W-1:0]  found_position,
  input logic signed [rtfmae_pkg::OUT_W-1:0]    old_word,
  input logic signed [rtfmae_pkg::OUT_W-1:0]    new_word,
  input logic [rtfmae_pkg::STATUS_W-1:0]        status
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(found_position) && $stable(old_word) && $stable(new_word))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an operation is in flight");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (found_position != '1) |-> status == rtfmae_pkg::ST_OK)
    else $error("match position with non-ok status");

  a_notfound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == rtfmae_pkg::ST_NOTFOUND) |->
      (found_position == '1) && (old_word == '0) && (new_word == '0))
    else $error("not-found result carries data");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == rtfmae_pkg::ST_FULL) |->
      (found_position == '1) && (old_word == '0) && (new_word == '0))
    else $error("table-full result carries data");

endmodule

bind ragged_table_find_modify_append_erase_top rtfmae_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .found_position (rsp.found_position),
  .old_word       (rsp.old_word),
  .new_word       (rsp.new_word),
  .status         (rsp.status)
);

// ----- tb/ragged_table_find_modify_append_erase_top_tb.sv -----
`timescale 1ns / 1ps

module ragged_table_find_modify_append_erase_top_tb;

  // Watchdog: the limit covers ~1170 transfers, each at worst a full find, plus long
  // gaps and long stalls on both sides.
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_OPS   = 1150;
  // Drain margin after the last result: longest find plus the output register.
  localparam int DRAIN_CYCLES = 130;

  logic clk;
  logic rst;

  rtfmae_req_if req_ch ();
  rtfmae_rsp_if rsp_ch ();

  ragged_table_find_modify_append_erase_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Mirror of the table contents, kept in step with accepted transfers
  rtfmae_pkg::cell_t mirror_cells [rtfmae_pkg::CELL_COUNT];
  int                mirror_len   [rtfmae_pkg::ROWS];
  int                mirror_rows;

  rtfmae_pkg::res_t  pending_results [$];

  int    error_count;
  int    checked_count;
  int    cycles;
  int    sent_by_mode [4];
  int    status_seen  [8];
  bit    src_calm;
  bit    sink_calm;

  typedef struct {
    rtfmae_pkg::item_t op;
    bit                fixed;
    rtfmae_pkg::res_t  want;
  } script_row_t;

  script_row_t script [$];

  function automatic rtfmae_pkg::res_t mk_res(
      input logic signed [rtfmae_pkg::FOUND_W-1:0] fp,
      input logic [rtfmae_pkg::OUT_W-1:0] ow,
      input logic [rtfmae_pkg::OUT_W-1:0] nw,
      input logic [rtfmae_pkg::STATUS_W-1:0] st);
    rtfmae_pkg::res_t r;
    r.found_position = fp;
    r.old_word       = ow;
    r.new_word       = nw;
    r.status         = st;
    return r;
  endfunction

  function automatic bit entry_present(input int row, input int col);
    return (row < mirror_rows) && (row < rtfmae_pkg::ROWS) && (col < mirror_len[row]);
  endfunction

  // Applies one operation to the mirror and returns the result it must give.
  function automatic rtfmae_pkg::res_t apply_table_op(input rtfmae_pkg::item_t it);
    rtfmae_pkg::res_t  r;
    int                row;
    int                col;
    int                last;
    bit                hit;
    bit                need_row;
    rtfmae_pkg::cell_t w;
    r   = mk_res(-1, '0, '0, rtfmae_pkg::ST_OK);
    row = it.position / rtfmae_pkg::COLS;
    col = it.position % rtfmae_pkg::COLS;
    w   = rtfmae_pkg::cell_t'(it.word);   // sign-extend, then keep the stored width
    case (it.mode)
      rtfmae_pkg::MODE_FIND: begin
        hit = 1'b0;
        for (int rr = 0; rr < mirror_rows && !hit; rr++) begin
          for (int cc = 0; cc < mirror_len[rr] && !hit; cc++) begin
            if (mirror_cells[rr*rtfmae_pkg::COLS+cc] == w) begin
              hit = 1'b1;
              r.found_position = rtfmae_pkg::FOUND_W'(rr*rtfmae_pkg::COLS + cc);
            end
          end
        end
        r.status = hit ? rtfmae_pkg::ST_OK : rtfmae_pkg::ST_NOTFOUND;
      end
      rtfmae_pkg::MODE_MODIFY: begin
        if (it.position >= rtfmae_pkg::CELL_COUNT) begin
          r = mk_res(-1, '1, '1, rtfmae_pkg::ST_INVALID);
        end else if (!entry_present(row, col)) begin
          r = mk_res(-1, '1, '1, rtfmae_pkg::ST_MISSING);
        end else begin
          r.old_word = rtfmae_pkg::OUT_W'(mirror_cells[row*rtfmae_pkg::COLS+col]);
          r.new_word = rtfmae_pkg::OUT_W'(w);
          mirror_cells[row*rtfmae_pkg::COLS+col] = w;
        end
      end
      rtfmae_pkg::MODE_APPEND: begin
        need_row = (mirror_rows == 0) ||
                   (mirror_len[mirror_rows-1] >= rtfmae_pkg::COLS);
        if (need_row && mirror_rows >= rtfmae_pkg::ROWS) begin
          r.status = rtfmae_pkg::ST_FULL;
        end else begin
          if (need_row) mirror_rows++;
          last = mirror_rows - 1;
          mirror_cells[last*rtfmae_pkg::COLS + mirror_len[last]] = w;
          mirror_len[last]++;
        end
      end
      default: begin
        if (it.position >= rtfmae_pkg::CELL_COUNT) begin
          r.status = rtfmae_pkg::ST_INVALID;
        end else if (!entry_present(row, col)) begin
          r.status = rtfmae_pkg::ST_MISSING;
        end else if (it.erase_flag) begin
          for (int c = col; c + 1 < mirror_len[row]; c++)
            mirror_cells[row*rtfmae_pkg::COLS+c] = mirror_cells[row*rtfmae_pkg::COLS+c+1];
          mirror_len[row]--;
        end else begin
          mirror_cells[row*rtfmae_pkg::COLS+col] = '0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_row(input logic [rtfmae_pkg::MODE_W-1:0] mode, input int pos,
                         input logic [31:0] word, input bit erase,
                         input bit fixed, input rtfmae_pkg::res_t want);
    script_row_t s;
    s.op.mode       = mode;
    s.op.position   = rtfmae_pkg::POS_W'(pos);
    s.op.word       = word;
    s.op.erase_flag = erase;
    s.fixed         = fixed;
    s.want          = want;
    script.insert(script.size(), s);
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle(input bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random operation, steered toward positions and words that exist in the table
  function automatic rtfmae_pkg::item_t make_random_item(input int n);
    rtfmae_pkg::item_t it;
    int                rr;
    int                col;
    int                sel;
    it.mode       = rtfmae_pkg::MODE_W'($urandom_range(3));
    it.position   = rtfmae_pkg::POS_W'($urandom);
    it.word       = $urandom;
    it.erase_flag = 1'($urandom);
    if ($urandom_range(99) < 12) return it;   // unshaped noise

    // heavy appends early so the table fills and then hits full
    if ($urandom_range(99) < ((n < 250) ? 55 : 25)) begin
      it.mode = rtfmae_pkg::MODE_APPEND;
    end else begin
      case ($urandom_range(2))
        0:       it.mode = rtfmae_pkg::MODE_FIND;
        1:       it.mode = rtfmae_pkg::MODE_MODIFY;
        default: it.mode = rtfmae_pkg::MODE_EDIT;
      endcase
    end

    sel = $urandom_range(9);
    if (sel == 0)      it.word = 32'h7FFF_FFFF;
    else if (sel == 1) it.word = 32'h8000_0000;
    else if (sel < 5)  it.word = 32'($signed($urandom_range(16)) - 8);

    if (mirror_rows > 0 && $urandom_range(99) < 80) begin
      rr  = $urandom_range(mirror_rows - 1);
      col = (mirror_len[rr] == 0) ? $urandom_range(rtfmae_pkg::COLS - 1)
                                  : $urandom_range(mirror_len[rr] - 1);
      if ($urandom_range(9) == 0) col = mirror_len[rr] % rtfmae_pkg::COLS;   // just past the end
      it.position = rtfmae_pkg::POS_W'(rr*rtfmae_pkg::COLS + col);
      if (it.mode == rtfmae_pkg::MODE_FIND && mirror_len[rr] > 0 &&
          $urandom_range(99) < 60)
        it.word = mirror_cells[rr*rtfmae_pkg::COLS + $urandom_range(mirror_len[rr] - 1)];
    end else if ($urandom_range(1) == 0) begin
      it.position = rtfmae_pkg::POS_W'($urandom_range(rtfmae_pkg::CELL_COUNT - 1));
    end
    return it;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < 10) $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Drives one item and returns, at the transfer edge, what the mirror predicts.
  // valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input rtfmae_pkg::item_t it, output rtfmae_pkg::res_t predicted);
    int gap;
    gap = pick_idle(src_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= it.mode;
    req_ch.position   <= it.position;
    req_ch.word       <= it.word;
    req_ch.erase_flag <= it.erase_flag;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_table_op(it);
    sent_by_mode[it.mode]++;
  endtask

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("ragged_table_find_modify_append_erase_top_tb: done, errors");
      $finish;
    end
  end

  // Result side back-pressure, with calm stretches chosen at random
  initial begin
    int stall_left;
    stall_left = 0;
    sink_calm  = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycles % 512 == 0) sink_calm = ($urandom_range(3) == 0);
      if (stall_left == 0 && !sink_calm && $urandom_range(99) < 20)
        stall_left = pick_idle(1'b0);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Checker: each transfer on the result side against the oldest expectation
  always @(posedge clk) begin
    rtfmae_pkg::res_t got;
    rtfmae_pkg::res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.found_position = rsp_ch.found_position;
      got.old_word       = rsp_ch.old_word;
      got.new_word       = rsp_ch.new_word;
      got.status         = rsp_ch.status;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: found %0d old %h new %h status %0d",
                               got.found_position, got.old_word, got.new_word,
                               got.status));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got !== want)
          report_error($sformatf({"result %0d mismatch: found %0d/%0d old %h/%h ",
                                  "new %h/%h status %0d/%0d (expected/actual)"},
                                 checked_count, want.found_position, got.found_position,
                                 want.old_word, got.old_word, want.new_word,
                                 got.new_word, want.status, got.status));
      end
    end
  end

  // Stimulus
  initial begin
    rtfmae_pkg::item_t it;
    rtfmae_pkg::res_t  predicted;
    error_count   = 0;
    checked_count = 0;
    cycles        = 0;
    src_calm      = 1'b0;
    mirror_rows   = 0;
    foreach (mirror_len[i])   mirror_len[i]   = 0;
    foreach (mirror_cells[i]) mirror_cells[i] = '0;
    foreach (sent_by_mode[i]) sent_by_mode[i] = 0;
    foreach (status_seen[i])  status_seen[i]  = 0;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= rtfmae_pkg::MODE_FIND;
    req_ch.position    <= '0;
    req_ch.word        <= '0;
    req_ch.erase_flag  <= 1'b0;

    // Directed: empty table, bad indexes, word extremes, then edits on a short row.
    // Rows flagged fixed carry a hand-written result; the rest use the mirror.
    add_row(rtfmae_pkg::MODE_FIND,     0, 32'h0,         1'b0, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_NOTFOUND));
    add_row(rtfmae_pkg::MODE_MODIFY,   0, 32'h7,         1'b0, 1'b1,
            mk_res(-1, '1, '1, rtfmae_pkg::ST_MISSING));
    add_row(rtfmae_pkg::MODE_MODIFY, 127, 32'h7,         1'b1, 1'b1,
            mk_res(-1, '1, '1, rtfmae_pkg::ST_INVALID));
    add_row(rtfmae_pkg::MODE_MODIFY, 100, 32'h0,         1'b0, 1'b1,
            mk_res(-1, '1, '1, rtfmae_pkg::ST_INVALID));
    add_row(rtfmae_pkg::MODE_EDIT,   100, 32'h0,         1'b1, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_INVALID));
    add_row(rtfmae_pkg::MODE_EDIT,     0, 32'h0,         1'b0, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_MISSING));
    add_row(rtfmae_pkg::MODE_APPEND,   0, 32'h7FFF_FFFF, 1'b1, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_OK));
    add_row(rtfmae_pkg::MODE_APPEND, 127, 32'h8000_0000, 1'b0, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_OK));
    add_row(rtfmae_pkg::MODE_APPEND,   0, 32'h0,         1'b0, 1'b0, '0);
    add_row(rtfmae_pkg::MODE_APPEND,   0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(rtfmae_pkg::MODE_APPEND,   0, 32'h8000_0000, 1'b0, 1'b0, '0);   // duplicate value
    add_row(rtfmae_pkg::MODE_FIND,    64, 32'h8000_0000, 1'b0, 1'b1,
            mk_res(1, 0, 0, rtfmae_pkg::ST_OK));
    add_row(rtfmae_pkg::MODE_FIND,     0, 32'd12345,     1'b1, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_NOTFOUND));
    add_row(rtfmae_pkg::MODE_MODIFY,   1, 32'd5,         1'b0, 1'b1,
            mk_res(-1, 32'h8000_0000, 32'd5, rtfmae_pkg::ST_OK));
    add_row(rtfmae_pkg::MODE_MODIFY,   5, 32'd1,         1'b0, 1'b1,
            mk_res(-1, '1, '1, rtfmae_pkg::ST_MISSING));
    add_row(rtfmae_pkg::MODE_MODIFY,  10, 32'd1,         1'b0, 1'b1,
            mk_res(-1, '1, '1, rtfmae_pkg::ST_MISSING));
    add_row(rtfmae_pkg::MODE_EDIT,     0, 32'h0,         1'b0, 1'b0, '0);   // overwrite with zero
    add_row(rtfmae_pkg::MODE_FIND,     0, 32'h0,         1'b0, 1'b0, '0);
    add_row(rtfmae_pkg::MODE_EDIT,     1, 32'h0,         1'b1, 1'b0, '0);   // erase mid-row
    add_row(rtfmae_pkg::MODE_EDIT,     3, 32'h0,         1'b1, 1'b0, '0);   // erase last entry
    add_row(rtfmae_pkg::MODE_FIND,     0, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(rtfmae_pkg::MODE_MODIFY,   2, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_row(rtfmae_pkg::MODE_EDIT,    99, 32'h0,         1'b0, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_MISSING));
    add_row(rtfmae_pkg::MODE_EDIT,   127, 32'h0,         1'b0, 1'b1,
            mk_res(-1, 0, 0, rtfmae_pkg::ST_INVALID));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_item(script[i].op, predicted);
      pending_results.insert(pending_results.size(),
                             script[i].fixed ? script[i].want : predicted);
    end

    // Random: fill to full early, then a mix that erases and refills
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 64 == 0) src_calm = ($urandom_range(3) == 0);
      it = make_random_item(n);
      send_item(it, predicted);
      pending_results.insert(pending_results.size(), predicted);
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d find, %0d modify, %0d append, %0d replace/remove; %0d results checked",
             sent_by_mode[rtfmae_pkg::MODE_FIND], sent_by_mode[rtfmae_pkg::MODE_MODIFY],
             sent_by_mode[rtfmae_pkg::MODE_APPEND], sent_by_mode[rtfmae_pkg::MODE_EDIT],
             checked_count);
    $display("status mix: ok %0d, invalid %0d, full %0d, missing %0d, not found %0d",
             status_seen[rtfmae_pkg::ST_OK], status_seen[rtfmae_pkg::ST_INVALID],
             status_seen[rtfmae_pkg::ST_FULL], status_seen[rtfmae_pkg::ST_MISSING],
             status_seen[rtfmae_pkg::ST_NOTFOUND]);
    if (error_count == 0) begin
      $display("ragged_table_find_modify_append_erase_top_tb: done, clean");
    end else begin
      $display("%0d errors", error_count);
      $display("ragged_table_find_modify_append_erase_top_tb: done, errors");
    end
    $finish;
  end

endmodule
